@@ src/pmmf_pkg.sv @@
`default_nettype none

package pmmf_pkg;

	// History depth default and fixed field widths.
	localparam int WINDOW_DEF = 8;
	localparam int XW         = 32;   // position sample width
	localparam int WINW       = 4;    // window register and held count width
	localparam int SW         = 36;   // sum of up to fifteen samples
	localparam int AW         = 37;   // shared adder width
	localparam int STEPW      = 6;    // divide step counter, holds SW
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_EN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_WIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_WIN   = 2'd3;

	localparam logic [WINW-1:0] MEDIAN_WIN_RST = 4'd5;
	localparam logic [WINW-1:0] MEAN_WIN_RST   = 4'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WIN,
		S_SUM,
		S_ABS,
		S_DIV,
		S_NEG,
		S_CAND,
		S_CMP,
		S_CHK,
		S_AVG,
		S_DONE
	} state_t;

	typedef struct packed {
		logic            median_en;
		logic            mean_en;
		logic [WINW-1:0] median_win;
		logic [WINW-1:0] mean_win;
	} cfg_t;

	typedef struct packed {
		logic shift;
		logic restart;
	} hist_ctrl_t;

endpackage

`default_nettype wire

@@ src/pmmf_alu.sv @@
`default_nettype none

module pmmf_alu (
	input  logic [pmmf_pkg::AW-1:0] a,
	input  logic [pmmf_pkg::AW-1:0] b,
	input  logic                    sub,
	output logic [pmmf_pkg::AW-1:0] sum,
	output logic                    neg,
	output logic                    zero
);
	import pmmf_pkg::*;

	logic [AW-1:0] b_op;

	// One adder serves accumulation, compares, negation, divide steps and the median midpoint.
	assign b_op = sub ? ~b : b;
	assign sum  = a + b_op + AW'(sub);
	assign neg  = sum[AW-1];
	assign zero = (sum == '0);

endmodule

`default_nettype wire

@@ src/pmmf_hist.sv @@
`default_nettype none

module pmmf_hist #(
	parameter int WINDOW = pmmf_pkg::WINDOW_DEF,
	parameter int CW     = $clog2(WINDOW + 1),
	parameter int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pmmf_pkg::hist_ctrl_t   ctrl,
	input  logic [pmmf_pkg::XW-1:0] wr_x,
	input  logic [pmmf_pkg::XW-1:0] wr_y,
	input  logic [IW-1:0]          rd_idx,
	output logic [pmmf_pkg::XW-1:0] rd_x,
	output logic [pmmf_pkg::XW-1:0] rd_y,
	output logic [CW-1:0]          count
);
	import pmmf_pkg::*;

	logic [XW-1:0] hist_x_q [WINDOW];
	logic [XW-1:0] hist_y_q [WINDOW];
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_base;

	// Newest sample sits at entry 0; the oldest falls off the far end when full.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			hist_x_q[0] <= wr_x;
			hist_y_q[0] <= wr_y;
			for (int i = 1; i < WINDOW; i++) begin
				hist_x_q[i] <= hist_x_q[i-1];
				hist_y_q[i] <= hist_y_q[i-1];
			end
		end
	end

	assign count_base = ctrl.restart ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.shift) begin
			if (count_base == CW'(WINDOW)) begin
				count_q <= CW'(WINDOW);
			end else begin
				count_q <= count_base + CW'(1);
			end
		end
	end

	assign rd_x  = hist_x_q[rd_idx];
	assign rd_y  = hist_y_q[rd_idx];
	assign count = count_q;

endmodule

`default_nettype wire

@@ src/pmmf_seq.sv @@
`default_nettype none

module pmmf_seq #(
	parameter int WINDOW = pmmf_pkg::WINDOW_DEF,
	parameter int CW     = $clog2(WINDOW + 1),
	parameter int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pmmf_pkg::cfg_t            cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [pmmf_pkg::XW-1:0]   meas_x,
	input  logic [pmmf_pkg::XW-1:0]   meas_y,
	input  logic                      restart,
	output pmmf_pkg::hist_ctrl_t      hist_ctrl,
	output logic [IW-1:0]             rd_idx,
	input  logic [pmmf_pkg::XW-1:0]   rd_x,
	input  logic [pmmf_pkg::XW-1:0]   rd_y,
	input  logic [CW-1:0]             count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pmmf_pkg::XW-1:0]   filtered_x,
	output logic [pmmf_pkg::XW-1:0]   filtered_y,
	output logic [pmmf_pkg::WINW-1:0] held_count
);
	import pmmf_pkg::*;

	state_t state_q, state_d;

	logic [XW-1:0]    x_q, y_q;
	logic [XW-1:0]    res_x_q, res_y_q;
	logic             axis_q;
	logic [WINW-1:0]  w_q;
	logic [WINW-1:0]  i_q, j_q;
	logic [WINW-1:0]  lt_q, le_q;
	logic [XW-1:0]    cand_q, vlo_q, vhi_q;
	logic [SW-1:0]    acc_q;
	logic [WINW-1:0]  rem_q;
	logic [STEPW-1:0] step_q;
	logic             neg_q;
	logic             out_valid_q;
	logic [XW-1:0]    filt_x_q, filt_y_q;
	logic [WINW-1:0]  held_q;

	logic [AW-1:0]    alu_a, alu_b, alu_sum;
	logic             alu_sub, alu_neg, alu_zero;
	logic [XW-1:0]    rd_val;
	logic [WINW-1:0]  addr;
	logic             last_j;
	logic [WINW-1:0]  r_lo, r_hi;
	logic             out_free;
	logic [XW-1:0]    axis_res;

	logic [5:0]       w_pick, w_lim1, w_lim2;

	pmmf_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sub  (alu_sub),
		.sum  (alu_sum),
		.neg  (alu_neg),
		.zero (alu_zero)
	);

	assign rd_val   = axis_q ? rd_y : rd_x;
	assign addr     = (state_q == S_CAND) ? i_q : j_q;
	assign rd_idx   = IW'(addr);
	assign last_j   = (j_q == w_q - WINW'(1));
	assign r_lo     = (w_q - WINW'(1)) >> 1;
	assign r_hi     = w_q >> 1;
	assign out_free = !out_valid_q || out_ready;

	// Effective window: zero acts as one, then clipped to depth and fill.
	always_comb begin
		w_pick = cfg.mean_en ? {2'b00, cfg.mean_win} : {2'b00, cfg.median_win};
		if (w_pick == 6'd0) begin
			w_pick = 6'd1;
		end
		w_lim1 = (w_pick > 6'(WINDOW)) ? 6'(WINDOW) : w_pick;
		w_lim2 = (w_lim1 > 6'(count)) ? 6'(count) : w_lim1;
	end

	// Quotient sign fix or median midpoint, whichever finishes this axis.
	assign axis_res = (state_q == S_AVG) ? alu_sum[XW:1] :
	                  (neg_q ? alu_sum[XW-1:0] : acc_q[XW-1:0]);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_WIN;
				end
			end
			S_WIN: begin
				if (cfg.mean_en) begin
					state_d = S_SUM;
				end else if (cfg.median_en) begin
					state_d = S_CAND;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SUM: begin
				if (last_j) begin
					state_d = S_ABS;
				end
			end
			S_ABS: state_d = S_DIV;
			S_DIV: begin
				if (step_q == STEPW'(1)) begin
					state_d = S_NEG;
				end
			end
			S_NEG: state_d = axis_q ? S_DONE : S_SUM;
			S_CAND: state_d = S_CMP;
			S_CMP: begin
				if (last_j) begin
					state_d = S_CHK;
				end
			end
			S_CHK: state_d = (i_q == w_q - WINW'(1)) ? S_AVG : S_CAND;
			S_AVG: state_d = axis_q ? S_DONE : S_CAND;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready          = 1'b0;
		hist_ctrl.shift   = 1'b0;
		hist_ctrl.restart = restart;
		alu_a             = '0;
		alu_b             = '0;
		alu_sub           = 1'b0;
		unique case (state_q) inside
			S_IDLE: begin
				in_ready        = 1'b1;
				hist_ctrl.shift = in_valid;
			end
			S_SUM: begin
				alu_a = {{(AW-SW){acc_q[SW-1]}}, acc_q};
				alu_b = {{(AW-XW){rd_val[XW-1]}}, rd_val};
			end
			S_ABS, S_NEG: begin
				alu_b   = {{(AW-SW){acc_q[SW-1]}}, acc_q};
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a   = {{(AW-WINW-1){1'b0}}, rem_q, acc_q[SW-1]};
				alu_b   = {{(AW-WINW){1'b0}}, w_q};
				alu_sub = 1'b1;
			end
			S_CMP: begin
				alu_a   = {{(AW-XW){rd_val[XW-1]}}, rd_val};
				alu_b   = {{(AW-XW){cand_q[XW-1]}}, cand_q};
				alu_sub = 1'b1;
			end
			S_AVG: begin
				alu_a = {{(AW-XW){vlo_q[XW-1]}}, vlo_q};
				alu_b = {{(AW-XW){vhi_q[XW-1]}}, vhi_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			S_IDLE: begin
				if (in_valid) begin
					x_q <= meas_x;
					y_q <= meas_y;
				end
			end
			S_WIN: begin
				w_q     <= w_lim2[WINW-1:0];
				res_x_q <= x_q;
				res_y_q <= y_q;
				axis_q  <= 1'b0;
				acc_q   <= '0;
				i_q     <= '0;
				j_q     <= '0;
			end
			S_SUM: begin
				acc_q <= alu_sum[SW-1:0];
				j_q   <= j_q + WINW'(1);
			end
			S_ABS: begin
				neg_q  <= acc_q[SW-1];
				rem_q  <= '0;
				step_q <= STEPW'(SW);
				if (acc_q[SW-1]) begin
					acc_q <= alu_sum[SW-1:0];
				end
			end
			S_DIV: begin
				// Restoring step: quotient bits shift in as dividend bits shift out.
				step_q <= step_q - STEPW'(1);
				if (alu_neg) begin
					rem_q <= {rem_q[WINW-2:0], acc_q[SW-1]};
					acc_q <= {acc_q[SW-2:0], 1'b0};
				end else begin
					rem_q <= alu_sum[WINW-1:0];
					acc_q <= {acc_q[SW-2:0], 1'b1};
				end
			end
			S_CAND: begin
				cand_q <= rd_val;
				j_q    <= '0;
				lt_q   <= '0;
				le_q   <= '0;
			end
			S_CMP: begin
				j_q <= j_q + WINW'(1);
				if (alu_neg) begin
					lt_q <= lt_q + WINW'(1);
				end
				if (alu_neg || alu_zero) begin
					le_q <= le_q + WINW'(1);
				end
			end
			S_CHK: begin
				// The candidate fills sorted ranks lt through le-1.
				if (lt_q <= r_lo && r_lo < le_q) begin
					vlo_q <= cand_q;
				end
				if (lt_q <= r_hi && r_hi < le_q) begin
					vhi_q <= cand_q;
				end
				i_q <= i_q + WINW'(1);
			end
			S_NEG, S_AVG: begin
				if (axis_q) begin
					res_y_q <= axis_res;
				end else begin
					res_x_q <= axis_res;
				end
				axis_q <= 1'b1;
				acc_q  <= '0;
				i_q    <= '0;
				j_q    <= '0;
			end
			S_DONE: begin
				if (out_free) begin
					filt_x_q <= res_x_q;
					filt_y_q <= res_y_q;
					held_q   <= WINW'(count);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign filtered_x = filt_x_q;
	assign filtered_y = filt_y_q;
	assign held_count = held_q;

	a_accept_to_win: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_WIN)
		else $error("accepted sample did not start the window step");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done step");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < w_q)
		else $error("divide remainder not below divisor");

	a_cand_self: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> le_q > lt_q)
		else $error("median candidate missed itself in rank count");

	a_window_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CAND || state_q == S_SUM |-> w_q != '0 && 6'(w_q) <= 6'(count))
		else $error("window outside the held samples");

endmodule

`default_nettype wire

@@ src/position_median_mean_filter_top.sv @@
`default_nettype none
// Channel  Direction  Handshake             Payload
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in         in_valid/in_ready     meas_x, meas_y, restart
// out      out        out_valid/out_ready   filtered_x, filtered_y, held_count
//
// Each sample is filtered by the mean filter or by the median filter, or passes
// with neither, w being the effective window.
// The work runs through the single shared adder: a rank count of w compares per
// candidate for the median, and a sum then a 36-step restoring divide for the mean.
// Reset clears the fill count, the sequencer and the result valid; the history
// needs no clearing pass. A new beat is taken once the sequencer is back in idle,
// even while the last result still waits; a stalled output only holds the finish step.
// Configuration beats are always taken.

module position_median_mean_filter_top #(
	parameter int WINDOW = pmmf_pkg::WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pmmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmmf_pkg::WINW-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pmmf_pkg::XW-1:0]      meas_x,
	input  logic signed [pmmf_pkg::XW-1:0]      meas_y,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pmmf_pkg::XW-1:0]      filtered_x,
	output logic signed [pmmf_pkg::XW-1:0]      filtered_y,
	output logic [pmmf_pkg::WINW-1:0]           held_count
);
	import pmmf_pkg::*;

	localparam int CW = $clog2(WINDOW + 1);
	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	cfg_t          cfg_q;
	hist_ctrl_t    hist_ctrl;
	logic [IW-1:0] rd_idx;
	logic [XW-1:0] rd_x, rd_y;
	logic [CW-1:0] count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.median_en  <= 1'b1;
			cfg_q.mean_en    <= 1'b0;
			cfg_q.median_win <= MEDIAN_WIN_RST;
			cfg_q.mean_win   <= MEAN_WIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MEDIAN_EN:  cfg_q.median_en  <= cfg_data[0];
				REG_MEAN_EN:    cfg_q.mean_en    <= cfg_data[0];
				REG_MEDIAN_WIN: cfg_q.median_win <= cfg_data;
				REG_MEAN_WIN:   cfg_q.mean_win   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pmmf_hist #(
		.WINDOW (WINDOW),
		.CW     (CW),
		.IW     (IW)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hist_ctrl),
		.wr_x   (meas_x),
		.wr_y   (meas_y),
		.rd_idx (rd_idx),
		.rd_x   (rd_x),
		.rd_y   (rd_y),
		.count  (count)
	);

	pmmf_seq #(
		.WINDOW (WINDOW),
		.CW     (CW),
		.IW     (IW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.meas_x     (meas_x),
		.meas_y     (meas_y),
		.restart    (restart),
		.hist_ctrl  (hist_ctrl),
		.rd_idx     (rd_idx),
		.rd_x       (rd_x),
		.rd_y       (rd_y),
		.count      (count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered_x (filtered_x),
		.filtered_y (filtered_y),
		.held_count (held_count)
	);

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;

	localparam int HIST_DEPTH  = pmmf_pkg::WINDOW_DEF;
	localparam int XMAX        = 32'h7FFF_FFFF;
	localparam int XMIN        = 32'h8000_0000;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PHASES      = 30;
	localparam int PHASE_FIXES = 51;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [3:0]         held;
	} pos_fix_t;

	typedef enum bit {ROW_FIX, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                        kind;
		logic [pmmf_pkg::CFG_IDX_W-1:0]  idx;
		logic [pmmf_pkg::WINW-1:0]       data;
		bit                               rs;
		logic signed [31:0]               x;
		logic signed [31:0]               y;
		bit                               typed;
		pos_fix_t                         want;
	} plan_row_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [pmmf_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [pmmf_pkg::WINW-1:0]            cfg_data;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [31:0]                   meas_x;
	logic signed [31:0]                   meas_y;
	logic                                 restart;
	logic                                 out_valid;
	logic                                 out_ready;
	logic signed [31:0]                   filtered_x;
	logic signed [31:0]                   filtered_y;
	logic [3:0]                           held_count;

	// Filter state as the block should hold it.
	pmmf_pkg::cfg_t     filt_cfg;
	logic signed [31:0] hist [2][HIST_DEPTH];
	int                 fill;

	pos_fix_t    expected_fixes[$];
	plan_row_t   plan[$];
	int          errors;
	int unsigned cycle_count = 0;

	position_median_mean_filter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.meas_x     (meas_x),
		.meas_y     (meas_y),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered_x (filtered_x),
		.filtered_y (filtered_y),
		.held_count (held_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	function automatic void apply_reg(logic [pmmf_pkg::CFG_IDX_W-1:0] idx,
			logic [pmmf_pkg::WINW-1:0] data);
		case (idx)
			pmmf_pkg::REG_MEDIAN_EN:  filt_cfg.median_en  = data[0];
			pmmf_pkg::REG_MEAN_EN:    filt_cfg.mean_en    = data[0];
			pmmf_pkg::REG_MEDIAN_WIN: filt_cfg.median_win = data;
			pmmf_pkg::REG_MEAN_WIN:   filt_cfg.mean_win   = data;
			default: ;
		endcase
	endfunction

	function automatic int eff_window(logic [3:0] reg_w);
		int w;
		w = reg_w;
		if (w == 0) w = 1;
		if (w > HIST_DEPTH) w = HIST_DEPTH;
		if (w > fill) w = fill;
		return w;
	endfunction

	// Mean over the newest w entries, truncated toward zero.
	function automatic logic signed [31:0] axis_mean(int axis, int w);
		longint sum;
		int i;
		sum = 0;
		for (i = fill - w; i < fill; i++) sum += hist[axis][i];
		return 32'(sum / longint'(w));
	endfunction

	// Median over the newest w entries; an even count floors the midpoint.
	function automatic logic signed [31:0] axis_median(int axis, int w);
		longint t [HIST_DEPTH];
		longint v;
		int i, j;
		for (i = 0; i < w; i++) t[i] = hist[axis][fill - w + i];
		for (i = 1; i < w; i++) begin
			v = t[i];
			j = i;
			while (j > 0 && t[j-1] > v) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = v;
		end
		if (w % 2 == 1) return 32'(t[w/2]);
		return 32'((t[w/2-1] + t[w/2]) >>> 1);
	endfunction

	function automatic pos_fix_t filter_fix(bit rs, logic signed [31:0] x, logic signed [31:0] y);
		pos_fix_t fix;
		int i, w;
		if (rs) fill = 0;
		if (fill < HIST_DEPTH) begin
			hist[0][fill] = x;
			hist[1][fill] = y;
			fill++;
		end else begin
			for (i = 1; i < HIST_DEPTH; i++) begin
				hist[0][i-1] = hist[0][i];
				hist[1][i-1] = hist[1][i];
			end
			hist[0][HIST_DEPTH-1] = x;
			hist[1][HIST_DEPTH-1] = y;
		end
		fix.x    = x;
		fix.y    = y;
		fix.held = 4'(fill);
		if (filt_cfg.mean_en) begin
			w = eff_window(filt_cfg.mean_win);
			fix.x = axis_mean(0, w);
			fix.y = axis_mean(1, w);
		end else if (filt_cfg.median_en) begin
			w = eff_window(filt_cfg.median_win);
			fix.x = axis_median(0, w);
			fix.y = axis_median(1, w);
		end
		return fix;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Mostly small steps around a drifting base so that windows hold ties and
	// close values; the rest are extremes and fully random words.
	function automatic int pick_coord(int base);
		case ($urandom_range(0, 11)) inside
			0: begin
				case ($urandom_range(0, 3))
					0:       return XMIN;
					1:       return XMAX;
					2:       return 0;
					default: return -1;
				endcase
			end
			1, 2:    return $urandom;
			default: return base + $urandom_range(0, 16) - 8;
		endcase
	endfunction

	function automatic void plan_fix(bit rs, int x, int y, bit typed = 0,
			int ex = 0, int ey = 0, int eh = 0);
		plan_row_t row;
		row.kind      = ROW_FIX;
		row.idx       = '0;
		row.data      = '0;
		row.rs        = rs;
		row.x         = x;
		row.y         = y;
		row.typed     = typed;
		row.want.x    = ex;
		row.want.y    = ey;
		row.want.held = 4'(eh);
		plan.push_back(row);
	endfunction

	function automatic void plan_reg(logic [pmmf_pkg::CFG_IDX_W-1:0] idx,
			logic [pmmf_pkg::WINW-1:0] data);
		plan_row_t row;
		row.kind  = ROW_REG;
		row.idx   = idx;
		row.data  = data;
		row.rs    = 0;
		row.x     = 0;
		row.y     = 0;
		row.typed = 0;
		row.want  = '0;
		plan.push_back(row);
	endfunction

	// Register writes wait until every fix has come out, so the block is idle.
	task automatic write_reg(logic [pmmf_pkg::CFG_IDX_W-1:0] idx,
			logic [pmmf_pkg::WINW-1:0] data);
		in_valid <= 1'b0;
		while (expected_fixes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_fix(bit rs, logic signed [31:0] x, logic signed [31:0] y,
			bit typed, pos_fix_t want, int gap);
		pos_fix_t fix;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		meas_x   <= x;
		meas_y   <= y;
		restart  <= rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fix = filter_fix(rs, x, y);
		expected_fixes.push_back(typed ? want : fix);
	endtask

	task automatic report_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_fix();
		pos_fix_t want;
		if (expected_fixes.size() == 0) begin
			$display("%0t: unexpected beat x=%0d y=%0d held=%0d", $time,
				filtered_x, filtered_y, held_count);
			errors++;
		end else begin
			want = expected_fixes.pop_front();
			report_field("filtered_x", want.x, filtered_x);
			report_field("filtered_y", want.y, filtered_y);
			report_field("held_count", want.held, held_count);
		end
	endtask

	// Output side: random stalls, calm stretches, and two long hold-offs that
	// back the block up into its input.
	initial begin
		int hold;
		int unsigned seen;
		hold      = 0;
		seen      = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				check_fix();
				seen++;
				if (seen == 400 || seen == 1100) hold = 500;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if ((cycle_count / 3000) % 4 == 1) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				hold = idle_len();
			end
		end
	end

	initial begin
		int i, phase, n, base_x, base_y;
		bit calm, med_en, mean_en;
		logic [3:0] med_w, mean_w;
		plan_row_t row;

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		meas_x    = '0;
		meas_y    = '0;
		restart   = 1'b0;
		errors    = 0;
		fill      = 0;
		filt_cfg.median_en  = 1'b1;
		filt_cfg.mean_en    = 1'b0;
		filt_cfg.median_win = pmmf_pkg::MEDIAN_WIN_RST;
		filt_cfg.mean_win   = pmmf_pkg::MEAN_WIN_RST;

		// Reset settings: median over five.
		plan_fix(1, XMAX, XMIN, 1, XMAX, XMIN, 1);
		plan_fix(0, XMIN, XMAX, 1, -1, -1, 2);
		plan_fix(0, -1, 0, 1, -1, 0, 3);
		plan_fix(0, 100, -100);
		plan_fix(0, 7, 7);
		plan_fix(0, -5, 3);
		plan_fix(0, 1, 2);
		plan_fix(0, 3, 4);
		plan_fix(0, 9, -9);
		plan_fix(1, 42, -42, 1, 42, -42, 1);
		// Mean with a window of zero, then one far above the depth.
		plan_reg(pmmf_pkg::REG_MEAN_EN, 4'd1);
		plan_reg(pmmf_pkg::REG_MEAN_WIN, 4'd0);
		plan_fix(0, 10, -10, 1, 10, -10, 2);
		plan_reg(pmmf_pkg::REG_MEAN_WIN, 4'd15);
		plan_fix(0, -7, 3);
		plan_fix(0, XMIN, XMIN);
		plan_fix(0, XMIN, XMAX);
		plan_fix(0, XMIN, XMIN);
		plan_fix(0, XMIN, XMIN);
		plan_fix(0, XMIN, XMIN);
		plan_fix(0, XMIN, XMIN);
		// Both filters off; only bit zero of the data counts for an enable.
		plan_reg(pmmf_pkg::REG_MEAN_EN, 4'b1110);
		plan_reg(pmmf_pkg::REG_MEDIAN_EN, 4'b0000);
		plan_fix(0, 32'h1234_5678, 32'hEDCB_A988, 1, 32'h1234_5678, 32'hEDCB_A988, 8);
		plan_reg(pmmf_pkg::REG_MEDIAN_EN, 4'd1);
		plan_reg(pmmf_pkg::REG_MEDIAN_WIN, 4'd8);
		plan_fix(0, 5, -5);
		plan_reg(pmmf_pkg::REG_MEDIAN_WIN, 4'd0);
		plan_fix(0, 6, 6, 1, 6, 6, 8);
		plan_reg(pmmf_pkg::REG_MEDIAN_WIN, 4'd15);
		plan_fix(0, -3, 4);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < plan.size(); i++) begin
			row = plan[i];
			if (row.kind == ROW_REG)
				write_reg(row.idx, row.data);
			else
				send_fix(row.rs, row.x, row.y, row.typed, row.want, idle_len());
		end

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin med_en = 1; mean_en = 0; med_w = 8;  mean_w = 5;  end
				1: begin med_en = 1; mean_en = 0; med_w = 1;  mean_w = 8;  end
				2: begin med_en = 0; mean_en = 1; med_w = 8;  mean_w = 8;  end
				3: begin med_en = 1; mean_en = 1; med_w = 15; mean_w = 0;  end
				4: begin med_en = 0; mean_en = 0; med_w = 3;  mean_w = 3;  end
				5: begin med_en = 1; mean_en = 0; med_w = 0;  mean_w = 15; end
				6: begin med_en = 0; mean_en = 1; med_w = 15; mean_w = 1;  end
				default: begin
					med_en  = $urandom_range(0, 1);
					mean_en = ($urandom_range(0, 2) == 0);
					med_w   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
						: $urandom_range(1, 8);
					mean_w  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
						: $urandom_range(1, 8);
				end
			endcase
			write_reg(pmmf_pkg::REG_MEDIAN_EN, {3'($urandom), med_en});
			write_reg(pmmf_pkg::REG_MEAN_EN, {3'($urandom), mean_en});
			write_reg(pmmf_pkg::REG_MEDIAN_WIN, med_w);
			write_reg(pmmf_pkg::REG_MEAN_WIN, mean_w);
			base_x = $urandom;
			base_y = $urandom;
			calm   = (phase % 5 == 2);
			for (n = 0; n < PHASE_FIXES; n++) begin
				if ($urandom_range(0, 49) == 0) begin
					base_x = $urandom;
					base_y = $urandom;
				end
				send_fix($urandom_range(0, 24) == 0, pick_coord(base_x), pick_coord(base_y),
					0, '0, calm ? 0 : idle_len());
			end
		end

		in_valid <= 1'b0;
		while (expected_fixes.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
